// ----- rtl/core/prc_pkg.sv -----
`default_nettype none
package prc_pkg;
  localparam int COORD_BITS = 16;
  localparam int NUM_STAGES = 4;
  localparam int PROD_BITS = 2 * COORD_BITS + 2;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int QCNT_BITS = $clog2(PROD_BITS + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  // token passed along the chain of cells
  typedef struct packed {
    logic is_end;
    vtx_t v;
  } tok_t;

  typedef enum logic [1:0] {
    PLANE_BOTTOM = 2'd0,
    PLANE_RIGHT  = 2'd1,
    PLANE_TOP    = 2'd2,
    PLANE_LEFT   = 2'd3
  } plane_t;

  typedef enum logic [1:0] {
    REG_X_LOW  = 2'd0,
    REG_X_HIGH = 2'd1,
    REG_Y_LOW  = 2'd2,
    REG_Y_HIGH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIV,
    CS_EMIT_X,
    CS_EMIT_V,
    CS_END
  } cell_state_t;
endpackage
`default_nettype wire

// ----- rtl/core/prc_cell.sv -----
`default_nettype none
module prc_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  prc_pkg::plane_t     plane,
  input  prc_pkg::coord_t     bound,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  prc_pkg::tok_t       in_tok,
  output logic                out_valid,
  input  wire logic           out_stall,
  output prc_pkg::tok_t       out_tok
);
  import prc_pkg::*;

  cell_state_t state_r, state_nxt;
  logic        started_r, started_nxt;
  vtx_t        first_r, first_nxt;
  vtx_t        prev_r, prev_nxt;
  vtx_t        p1_r, p1_nxt;
  vtx_t        p2_r, p2_nxt;
  logic        emit_v_r, emit_v_nxt;
  logic        pend_end_r, pend_end_nxt;
  logic        neg_r, neg_nxt;
  logic [PROD_BITS-1:0] mag_r, mag_nxt;
  logic [PROD_BITS-1:0] rem_r, rem_nxt;
  logic [PROD_BITS-1:0] quo_r, quo_nxt;
  logic [DIFF_BITS-1:0] mdc_r, mdc_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  vtx_t        xres;

  logic        in1, in2, vert;
  logic signed [DIFF_BITS-1:0] d_s, dc_s, da_s;
  logic [DIFF_BITS-1:0] md, mda, mdc;
  logic [PROD_BITS:0]   trial;
  logic [PROD_BITS-1:0] rem_sh;
  logic [QCNT_BITS-1:0] bit_sel;
  logic signed [PROD_BITS+1:0] base;
  coord_t a1;

  function automatic logic inside_f(plane_t p, coord_t b, vtx_t v);
    logic r;
    r = 1'b0;
    unique case (p)
      PLANE_BOTTOM: r = (v.y >= b);
      PLANE_RIGHT:  r = (v.x <= b);
      PLANE_TOP:    r = (v.y <= b);
      PLANE_LEFT:   r = (v.x >= b);
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  assign vert = (plane == PLANE_BOTTOM) || (plane == PLANE_TOP);
  assign in1  = inside_f(plane, bound, p1_r);
  assign in2  = inside_f(plane, bound, p2_r);

  // differences along the plane normal (c) and the other axis (a)
  always_comb begin
    if (vert) begin
      d_s  = DIFF_BITS'(bound) - DIFF_BITS'(p1_r.y);
      dc_s = DIFF_BITS'(p2_r.y) - DIFF_BITS'(p1_r.y);
      da_s = DIFF_BITS'(p2_r.x) - DIFF_BITS'(p1_r.x);
      a1   = p1_r.x;
    end else begin
      d_s  = DIFF_BITS'(bound) - DIFF_BITS'(p1_r.x);
      dc_s = DIFF_BITS'(p2_r.x) - DIFF_BITS'(p1_r.x);
      da_s = DIFF_BITS'(p2_r.y) - DIFF_BITS'(p1_r.y);
      a1   = p1_r.y;
    end
    md  = d_s[DIFF_BITS-1]  ? DIFF_BITS'(-d_s)  : DIFF_BITS'(d_s);
    mdc = dc_s[DIFF_BITS-1] ? DIFF_BITS'(-dc_s) : DIFF_BITS'(dc_s);
    mda = da_s[DIFF_BITS-1] ? DIFF_BITS'(-da_s) : DIFF_BITS'(da_s);
  end

  assign bit_sel = QCNT_BITS'(PROD_BITS - 1) - cnt_r;
  assign rem_sh  = {rem_r[PROD_BITS-2:0], mag_r[bit_sel]};
  assign trial   = {1'b0, rem_sh} - {{(PROD_BITS+1-DIFF_BITS){1'b0}}, mdc_r};

  // crossing result, truncated toward zero
  always_comb begin
    base = (PROD_BITS+2)'(a1) +
           (neg_r ? -(PROD_BITS+2)'(quo_r) : (PROD_BITS+2)'(quo_r));
    if (mdc_r == '0) begin
      base = (PROD_BITS+2)'(a1);
    end else if (rem_r != '0 && mag_r != '0) begin
      if (neg_r && base > 0) base = base - 1;
      else if (!neg_r && base < 0) base = base + 1;
    end
    if (vert) begin
      xres.x = base[COORD_BITS-1:0];
      xres.y = bound;
    end else begin
      xres.x = bound;
      xres.y = base[COORD_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          if (in_tok.is_end) begin
            state_nxt = started_r ? CS_MUL : CS_END;
          end else if (started_r) begin
            state_nxt = CS_MUL;
          end
        end
      end
      CS_MUL: begin
        if (in1 && in2) state_nxt = CS_EMIT_V;
        else if (!in1 && !in2) state_nxt = pend_end_r ? CS_END : CS_IDLE;
        else state_nxt = CS_DIV;
      end
      CS_DIV:    if (cnt_r == QCNT_BITS'(PROD_BITS - 1)) state_nxt = CS_EMIT_X;
      CS_EMIT_X: if (!out_stall) state_nxt = emit_v_r ? CS_EMIT_V :
                                              (pend_end_r ? CS_END : CS_IDLE);
      CS_EMIT_V: if (!out_stall) state_nxt = pend_end_r ? CS_END : CS_IDLE;
      CS_END:    if (!out_stall) state_nxt = CS_IDLE;
      default:   state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != CS_IDLE);
    out_valid = 1'b0;
    out_tok   = '0;
    unique case (state_r)
      CS_EMIT_X: begin
        out_valid = 1'b1;
        out_tok.v = xres;
      end
      CS_EMIT_V: begin
        out_valid = 1'b1;
        out_tok.v = p2_r;
      end
      CS_END: begin
        out_valid = 1'b1;
        out_tok.is_end = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    started_nxt  = started_r;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    p1_nxt       = p1_r;
    p2_nxt       = p2_r;
    emit_v_nxt   = emit_v_r;
    pend_end_nxt = pend_end_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    mdc_nxt      = mdc_r;
    cnt_nxt      = cnt_r;
    if (state_r == CS_IDLE && in_valid) begin
      pend_end_nxt = in_tok.is_end;
      if (in_tok.is_end) begin
        started_nxt = 1'b0;
        p1_nxt = prev_r;
        p2_nxt = first_r;
      end else if (!started_r) begin
        started_nxt = 1'b1;
        first_nxt = in_tok.v;
        prev_nxt  = in_tok.v;
      end else begin
        p1_nxt   = prev_r;
        p2_nxt   = in_tok.v;
        prev_nxt = in_tok.v;
      end
    end
    if (state_r == CS_MUL) begin
      mag_nxt    = PROD_BITS'(md) * PROD_BITS'(mda);
      mdc_nxt    = mdc;
      neg_nxt    = (d_s[DIFF_BITS-1] ^ da_s[DIFF_BITS-1]) ^ dc_s[DIFF_BITS-1];
      emit_v_nxt = in2;
      rem_nxt    = '0;
      quo_nxt    = '0;
      cnt_nxt    = '0;
    end
    if (state_r == CS_DIV) begin
      // restoring divide, one quotient bit a cycle
      if (!trial[PROD_BITS]) begin
        rem_nxt = trial[PROD_BITS-1:0];
        quo_nxt = {quo_r[PROD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[PROD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CS_IDLE;
      started_r  <= 1'b0;
      pend_end_r <= 1'b0;
      first_r    <= '0;
      prev_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      started_r  <= started_nxt;
      pend_end_r <= pend_end_nxt;
      first_r    <= first_nxt;
      prev_r     <= prev_nxt;
    end
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    emit_v_r <= emit_v_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    mdc_r    <= mdc_nxt;
    cnt_r    <= cnt_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/prc_out.sv -----
`default_nettype none
module prc_out (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  prc_pkg::tok_t   in_tok,
  output logic            out_valid,
  input  wire logic       out_stall,
  output prc_pkg::coord_t out_x,
  output prc_pkg::coord_t out_y,
  output logic            vertex_valid,
  output logic            out_last
);
  import prc_pkg::*;

  logic hold_vld_r, hold_vld_nxt;
  vtx_t hold_r, hold_nxt;
  logic ov_r, ov_nxt;
  vtx_t ov_v_r, ov_v_nxt;
  logic ov_real_r, ov_real_nxt;
  logic ov_last_r, ov_last_nxt;
  logic take;

  // one-deep hold so the final vertex can carry the last flag
  assign in_stall = ov_r && out_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    ov_nxt       = ov_r && out_stall;
    ov_v_nxt     = ov_v_r;
    ov_real_nxt  = ov_real_r;
    ov_last_nxt  = ov_last_r;
    if (take) begin
      if (in_tok.is_end) begin
        ov_nxt       = 1'b1;
        ov_v_nxt     = hold_vld_r ? hold_r : '0;
        ov_real_nxt  = hold_vld_r;
        ov_last_nxt  = 1'b1;
        hold_vld_nxt = 1'b0;
      end else begin
        if (hold_vld_r) begin
          ov_nxt      = 1'b1;
          ov_v_nxt    = hold_r;
          ov_real_nxt = 1'b1;
          ov_last_nxt = 1'b0;
        end
        hold_nxt     = in_tok.v;
        hold_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      ov_r       <= ov_nxt;
    end
    hold_r    <= hold_nxt;
    ov_v_r    <= ov_v_nxt;
    ov_real_r <= ov_real_nxt;
    ov_last_r <= ov_last_nxt;
  end

  assign out_valid    = ov_r;
  assign out_x        = ov_v_r.x;
  assign out_y        = ov_v_r.y;
  assign vertex_valid = ov_real_r;
  assign out_last     = ov_last_r;
endmodule
`default_nettype wire

// ----- rtl/core/polygon_rect_clipper.sv -----
// channel | direction | handshake          | payload
// in_     | request   | in_valid/in_stall  | in_x, in_y, in_last
// out_    | result    | out_valid/out_stall| out_x, out_y, vertex_valid, out_last
// cfg_    | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
// each clip cell takes one request at a time: it takes the request, forms the
// product, runs the restoring divider when an edge crosses the plane, then hands
// on its vertices; it takes no new request until it is back in idle
// synchronous active-low reset empties all cells and loads the default window
// a stall at the output backs up through the chain to in_stall
`default_nettype none
module polygon_rect_clipper (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  prc_pkg::coord_t in_x,
  input  prc_pkg::coord_t in_y,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output prc_pkg::coord_t out_x,
  output prc_pkg::coord_t out_y,
  output logic            vertex_valid,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  prc_pkg::coord_t cfg_data
);
  import prc_pkg::*;

  coord_t x_low_r, x_high_r, y_low_r, y_high_r;
  coord_t bounds [NUM_STAGES];
  plane_t planes [NUM_STAGES];

  // chain links: link 0 is the input, link NUM_STAGES feeds the hold stage
  logic   lk_valid [NUM_STAGES+1];
  logic   lk_stall [NUM_STAGES+1];
  tok_t   lk_tok   [NUM_STAGES+1];
  tok_t   in_tok;

  assign cfg_ready = 1'b1;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= COORD_BITS'(50);
      x_high_r <= COORD_BITS'(250);
      y_low_r  <= COORD_BITS'(50);
      y_high_r <= COORD_BITS'(250);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_X_LOW:  x_low_r  <= cfg_data;
        REG_X_HIGH: x_high_r <= cfg_data;
        REG_Y_LOW:  y_low_r  <= cfg_data;
        REG_Y_HIGH: y_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bounds[0] = y_low_r;
  assign bounds[1] = x_high_r;
  assign bounds[2] = y_high_r;
  assign bounds[3] = x_low_r;
  assign planes[0] = PLANE_BOTTOM;
  assign planes[1] = PLANE_RIGHT;
  assign planes[2] = PLANE_TOP;
  assign planes[3] = PLANE_LEFT;

  // an input with the last flag becomes a vertex token then an end token
  logic split_r, split_nxt;
  always_comb begin
    split_nxt = split_r;
    if (!lk_stall[0] && in_valid && in_last) split_nxt = !split_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) split_r <= 1'b0;
    else split_r <= split_nxt;
  end

  assign in_tok.is_end = split_r;
  assign in_tok.v.x    = in_x;
  assign in_tok.v.y    = in_y;
  assign lk_valid[0]   = in_valid;
  assign lk_tok[0]     = in_tok;
  assign in_stall      = lk_stall[0] || (in_last && !split_r);

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    prc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .plane     (planes[g]),
      .bound     (bounds[g]),
      .in_valid  (lk_valid[g]),
      .in_stall  (lk_stall[g]),
      .in_tok    (lk_tok[g]),
      .out_valid (lk_valid[g+1]),
      .out_stall (lk_stall[g+1]),
      .out_tok   (lk_tok[g+1])
    );
  end

  prc_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (lk_valid[NUM_STAGES]),
    .in_stall     (lk_stall[NUM_STAGES]),
    .in_tok       (lk_tok[NUM_STAGES]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .vertex_valid (vertex_valid),
    .out_last     (out_last)
  );

`ifndef SYNTH
  // the empty marker is always the last item of a polygon
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !vertex_valid |-> out_last) else $error("empty marker not last");
  // an empty marker carries zero coordinates
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !vertex_valid |-> out_x == '0 && out_y == '0)
    else $error("empty marker not zero");
  // the end token half of a last request is never left pending after acceptance
  a_split_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> !split_r) else $error("split stuck");
`endif
endmodule
`default_nettype wire
